FILE: sv/sorted_priority_queue_unit_assert.svh
// assertion macros for the sorted priority queue rtl
// expects signals clk and arst_n in the including module
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// checked only outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: sv/spq_pkg.sv
// types and constants for the sorted priority queue
// no dependencies
package spq_pkg;

	localparam int unsigned SPQ_DEPTH = 64;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned CLS_W     = 4;
	localparam int unsigned ITEMS_W   = 8;
	localparam int unsigned OCC_W     = 7;
	localparam int unsigned SUM_W     = 14;

	typedef enum logic [1:0] {
		KIND_INSERT   = 2'd0,
		KIND_REMOVE   = 2'd1,
		KIND_POP_HEAD = 2'd2,
		KIND_POP_TAIL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_SCAN_RD,
		SQ_SCAN_CMP,
		SQ_MOVE_RD,
		SQ_MOVE_WR,
		SQ_INS_WR,
		SQ_FINISH
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [CLS_W-1:0]   cls;
		logic [ITEMS_W-1:0] items;
	} rec_t;

	typedef struct packed {
		status_t            status;
		rec_t               rec;
		logic [OCC_W-1:0]   occupancy;
		logic [SUM_W-1:0]   total;
	} res_t;

endpackage

FILE: sv/spq_ifs.sv
// request and response channel interfaces of the sorted priority queue
// depends on spq_pkg
interface spq_req_if;
	import spq_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [ID_W-1:0]    rec_id;
	logic [CLS_W-1:0]   rec_class;
	logic [ITEMS_W-1:0] rec_items;

	modport source (output valid, kind, rec_id, rec_class, rec_items, input ready);
	modport sink (input valid, kind, rec_id, rec_class, rec_items, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [ID_W-1:0]    out_id;
	logic [CLS_W-1:0]   out_class;
	logic [ITEMS_W-1:0] out_items;
	logic [OCC_W-1:0]   occupancy;
	logic [SUM_W-1:0]   total_items;

	modport source (output valid, status, out_id, out_class, out_items, occupancy,
		total_items, input ready);
	modport sink (input valid, status, out_id, out_class, out_items, occupancy,
		total_items, output ready);
endinterface

FILE: sv/spq_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module spq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: sv/spq_cmp.sv
// shared compare unit: decides whether the slot just read ends the scan
// depends on spq_pkg
module spq_cmp (
	input  spq_pkg::kind_t kind,
	input  logic           sort_by_items,
	input  logic           at_head,
	input  spq_pkg::rec_t  rec,
	input  spq_pkg::rec_t  slot,
	output logic           match
);
	import spq_pkg::*;

	logic [ITEMS_W-1:0] key_new;
	logic [ITEMS_W-1:0] key_slot;

	always_comb begin
		key_new  = sort_by_items ? rec.items  : ITEMS_W'(rec.cls);
		key_slot = sort_by_items ? slot.items : ITEMS_W'(slot.cls);
		unique case (kind)
			// head is passed over unless the new key is strictly below it
			KIND_INSERT:   match = at_head ? (key_new < key_slot) : !(key_slot < key_new);
			KIND_REMOVE:   match = (slot.id == rec.id);
			KIND_POP_HEAD: match = 1'b1;
			KIND_POP_TAIL: match = 1'b1;
			default:       match = 1'b0;
		endcase
	end
endmodule

FILE: sv/spq_ctrl.sv
// sequencer of the sorted priority queue: scans, shifts and updates slots
// depends on spq_pkg, spq_cmp and the assertion macro header
`include "sorted_priority_queue_unit_assert.svh"

module spq_ctrl #(
	parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sort_by_items,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  spq_pkg::kind_t           req_kind,
	input  spq_pkg::rec_t            req_rec,
	input  logic                     res_free,
	output logic                     res_load,
	output spq_pkg::res_t            res,
	output logic                     ram_we,
	output logic [$clog2(DEPTH)-1:0] ram_waddr,
	output spq_pkg::rec_t            ram_wdata,
	output logic [$clog2(DEPTH)-1:0] ram_raddr,
	input  spq_pkg::rec_t            ram_rdata
);
	import spq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	state_t           state_q, state_d;
	kind_t            kind_q, kind_d;
	rec_t             rec_q, rec_d;
	rec_t             taken_q, taken_d;
	status_t          status_q, status_d;
	logic [AW-1:0]    idx_q, idx_d;
	logic [AW-1:0]    pos_q, pos_d;
	logic [CW-1:0]    fill_q, fill_d;
	logic [SUM_W-1:0] sum_q, sum_d;

	logic          match;
	logic [CW:0]   fill_w;
	logic [CW:0]   idx_p1;
	logic [CW:0]   idx_p2;
	logic [AW-1:0] idx_m1;

	spq_cmp u_cmp (
		.kind          (kind_q),
		.sort_by_items (sort_by_items),
		.at_head       (idx_q == '0),
		.rec           (rec_q),
		.slot          (ram_rdata),
		.match         (match)
	);

	assign fill_w = (CW+1)'(fill_q);
	assign idx_p1 = (CW+1)'(idx_q) + 1'b1;
	assign idx_p2 = (CW+1)'(idx_q) + 2'd2;
	assign idx_m1 = idx_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			fill_q  <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			sum_q   <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		rec_q    <= rec_d;
		taken_q  <= taken_d;
		status_q <= status_d;
		idx_q    <= idx_d;
		pos_q    <= pos_d;
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		rec_d     = rec_q;
		taken_d   = taken_q;
		status_d  = status_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		fill_d    = fill_q;
		sum_d     = sum_q;
		req_ready = 1'b0;
		res_load  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = idx_q;
		res       = '{status: status_q, rec: taken_q, occupancy: OCC_W'(fill_q), total: sum_q};

		unique case (state_q)
			SQ_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					kind_d   = req_kind;
					rec_d    = req_rec;
					taken_d  = '0;
					status_d = ST_OK;
					idx_d    = '0;
					if (req_kind == KIND_INSERT) begin
						if (fill_q == CW'(DEPTH)) begin
							status_d = ST_FULL;
							state_d  = SQ_FINISH;
						end else if (fill_q == '0) begin
							pos_d   = '0;
							state_d = SQ_INS_WR;
						end else begin
							state_d = SQ_SCAN_RD;
						end
					end else if (fill_q == '0) begin
						status_d = ST_EMPTY;
						state_d  = SQ_FINISH;
					end else begin
						if (req_kind == KIND_POP_TAIL) begin
							idx_d = AW'(fill_q - 1'b1);
						end
						state_d = SQ_SCAN_RD;
					end
				end
			end
			SQ_SCAN_RD: begin
				state_d = SQ_SCAN_CMP;
			end
			SQ_SCAN_CMP: begin
				if (match) begin
					pos_d = idx_q;
					if (kind_q == KIND_INSERT) begin
						// open a gap by moving the tail end up, last slot first
						idx_d   = AW'(fill_q);
						state_d = SQ_MOVE_RD;
					end else begin
						taken_d = ram_rdata;
						state_d = (idx_p1 < fill_w) ? SQ_MOVE_RD : SQ_FINISH;
					end
				end else if (idx_p1 < fill_w) begin
					idx_d   = AW'(idx_p1);
					state_d = SQ_SCAN_RD;
				end else if (kind_q == KIND_INSERT) begin
					pos_d   = AW'(fill_q);
					state_d = SQ_INS_WR;
				end else begin
					status_d = ST_NOT_FOUND;
					state_d  = SQ_FINISH;
				end
			end
			SQ_MOVE_RD: begin
				ram_raddr = (kind_q == KIND_INSERT) ? idx_m1 : AW'(idx_p1);
				state_d   = SQ_MOVE_WR;
			end
			SQ_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				if (kind_q == KIND_INSERT) begin
					idx_d   = idx_m1;
					state_d = (idx_m1 > pos_q) ? SQ_MOVE_RD : SQ_INS_WR;
				end else begin
					idx_d   = AW'(idx_p1);
					state_d = (idx_p2 < fill_w) ? SQ_MOVE_RD : SQ_FINISH;
				end
			end
			SQ_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = rec_q;
				state_d   = SQ_FINISH;
			end
			SQ_FINISH: begin
				if (status_q == ST_OK) begin
					if (kind_q == KIND_INSERT) begin
						fill_d = fill_q + 1'b1;
						sum_d  = sum_q + SUM_W'(rec_q.items);
					end else begin
						fill_d = fill_q - 1'b1;
						sum_d  = sum_q - SUM_W'(taken_q.items);
					end
				end
				res = '{status: status_q, rec: taken_q, occupancy: OCC_W'(fill_d), total: sum_d};
				// hold here while the output register is still occupied
				if (res_free) begin
					res_load = 1'b1;
					state_d  = SQ_IDLE;
				end else begin
					fill_d = fill_q;
					sum_d  = sum_q;
				end
			end
			default: begin
				state_d = SQ_IDLE;
			end
		endcase
	end

	`SPQ_ASSERT(a_fill_bound, fill_q <= CW'(DEPTH), "fill count beyond queue depth")
	`SPQ_ASSERT(a_ins_pos, (state_q == SQ_INS_WR) |-> ((CW+1)'(pos_q) <= fill_w), "insert slot beyond tail")
	`SPQ_ASSERT(a_fill_step, res_load |=> ((fill_q == $past(fill_q) + 1'b1) || (fill_q == $past(fill_q) - 1'b1) || (fill_q == $past(fill_q))), "fill count jumped by more than one")
	`SPQ_ASSERT_ALWAYS(a_wr_state, ram_we |-> ((state_q == SQ_MOVE_WR) || (state_q == SQ_INS_WR)), "slot write outside a write step")
endmodule

FILE: sv/sorted_priority_queue_unit.sv
// top level of the sorted priority queue: channels, config register, result register
// depends on spq_pkg, spq_ifs, spq_ram and spq_ctrl
//
// usage:
//   req carries one operation (sorted insert, remove by id, pop head, pop tail);
//   rsp returns exactly one result per operation, in order, with status, the
//   removed record (zero if none), the occupancy and the running item total.
//   cfg_we/cfg_wdata set the sort key (0 class, 1 item count); write it only
//   while no operation is in flight.
// sequence:
//   records live in a ram with one write and one read port and registered read;
//   one compare unit checks one slot at a time, reading it and then comparing it;
//   every slot shifted is read and then written back, and an insert that is
//   stored ends with its own write; empty and full cases skip the scan.
//   req.ready is high only between operations.
// reset: the queue is empty, the item total zero and the key is the class.
// stall: a finished result sits in an output register, so the next request
//   can be taken while rsp is stalled; a second result waits in the
//   sequencer until the register frees.
module sorted_priority_queue_unit #(
	parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	spq_req_if.sink        req,
	spq_rsp_if.source      rsp
);
	import spq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic          sort_q;
	logic          res_valid_q;
	res_t          res_q;
	res_t          res;
	logic          res_load;
	logic          res_free;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	rec_t          ram_wdata;
	rec_t          ram_rdata;
	logic [$bits(rec_t)-1:0] ram_rdata_raw;
	rec_t          req_rec;

	assign req_rec  = '{id: req.rec_id, cls: req.rec_class, items: req.rec_items};
	assign res_free = !res_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				sort_q <= cfg_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	spq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.sort_by_items (sort_q),
		.req_valid     (req.valid),
		.req_ready     (req.ready),
		.req_kind      (kind_t'(req.kind)),
		.req_rec       (req_rec),
		.res_free      (res_free),
		.res_load      (res_load),
		.res           (res),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata)
	);

	spq_ram #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = rec_t'(ram_rdata_raw);

	assign rsp.valid       = res_valid_q;
	assign rsp.status      = res_q.status;
	assign rsp.out_id      = res_q.rec.id;
	assign rsp.out_class   = res_q.rec.cls;
	assign rsp.out_items   = res_q.rec.items;
	assign rsp.occupancy   = res_q.occupancy;
	assign rsp.total_items = res_q.total;
endmodule

FILE: tb/spq_order_checker.sv
// scoreboard for the sorted priority queue: mirrors the ordered records and the sort key,
// predicts one result per accepted operation and compares every response transfer
// depends on spq_pkg and spq_ifs
module spq_order_checker #(
	parameter int unsigned DEPTH = spq_pkg::SPQ_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	spq_req_if   req_mon,
	spq_rsp_if   rsp_mon,
	output int   fail_count,
	output int   pending,
	output int   results_checked
);
	import spq_pkg::*;

	rec_t             held[$];
	res_t             awaited[$];
	logic             by_items;
	logic [SUM_W-1:0] held_total;

	function automatic logic [ITEMS_W-1:0] sort_key(input rec_t r);
		return by_items ? r.items : ITEMS_W'(r.cls);
	endfunction

	function automatic res_t queue_op(input kind_t k, input rec_t r);
		res_t             res;
		int               pos;
		logic [ITEMS_W-1:0] new_key;
		res = '0;
		res.status = ST_OK;
		if (k == KIND_INSERT) begin
			if (held.size() >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				new_key = sort_key(r);
				if (held.size() == 0 || new_key < sort_key(held[0])) begin
					pos = 0;
				end else begin
					// past the head, go in front of the first entry whose key is not less
					pos = 1;
					while (pos < held.size() && sort_key(held[pos]) < new_key)
						pos++;
				end
				held.insert(pos, r);
				held_total += r.items;
			end
		end else if (held.size() == 0) begin
			res.status = ST_EMPTY;
		end else begin
			if (k == KIND_REMOVE) begin
				pos = 0;
				while (pos < held.size() && held[pos].id != r.id)
					pos++;
			end else if (k == KIND_POP_HEAD) begin
				pos = 0;
			end else begin
				pos = held.size() - 1;
			end
			if (pos >= held.size()) begin
				res.status = ST_NOT_FOUND;
			end else begin
				res.rec = held[pos];
				held_total -= held[pos].items;
				held.delete(pos);
			end
		end
		res.occupancy = OCC_W'(held.size());
		res.total = held_total;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		rec_t r;
		res_t want;
		if (!arst_n) begin
			held.delete();
			awaited.delete();
			by_items = 1'b0;
			held_total = '0;
			fail_count = 0;
			pending = 0;
			results_checked = 0;
		end else begin
			if (cfg_we)
				by_items = cfg_wdata;
			if (req_mon.valid && req_mon.ready) begin
				r.id = req_mon.rec_id;
				r.cls = req_mon.rec_class;
				r.items = req_mon.rec_items;
				awaited.push_back(queue_op(kind_t'(req_mon.kind), r));
			end
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (awaited.size() == 0) begin
					$error("response transfer with status %0d but no operation outstanding",
						rsp_mon.status);
					fail_count++;
				end else begin
					want = awaited.pop_front();
					check_field("status", want.status, rsp_mon.status);
					check_field("out_id", want.rec.id, rsp_mon.out_id);
					check_field("out_class", want.rec.cls, rsp_mon.out_class);
					check_field("out_items", want.rec.items, rsp_mon.out_items);
					check_field("occupancy", want.occupancy, rsp_mon.occupancy);
					check_field("total_items", want.total, rsp_mon.total_items);
					results_checked++;
				end
			end
			pending = awaited.size();
		end
	end

endmodule

FILE: tb/sorted_priority_queue_unit_test.sv
// testbench top for the sorted priority queue: clock, reset, operation stimulus in bursts,
// response stalls, key register writes between phases and the final verdict
// depends on spq_pkg, spq_ifs, spq_order_checker and sorted_priority_queue_unit
module sorted_priority_queue_unit_test;
	import spq_pkg::*;

	localparam int PHASES    = 6;
	localparam int PHASE_OPS = 175;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	int          fail_count;
	int          pending;
	int          results_checked;
	int          ops_sent;
	int          burst_left;
	int unsigned stall_cycle;
	int          stall_mode;
	logic [7:0]  stall_pat;

	// key per phase and share of inserts: heavy insert phases run into a full queue
	logic key_plan[PHASES]       = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
	int   insert_pct[PHASES]     = '{85, 30, 60, 90, 20, 55};

	spq_req_if req();
	spq_rsp_if rsp();

	sorted_priority_queue_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	spq_order_checker order_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.req_mon         (req),
		.rsp_mon         (rsp),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls: a randomly redrawn mode, from always ready to mostly stalled
	always @(negedge clk) begin
		if (stall_cycle % 96 == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_pat = 8'($urandom);
			stall_pat[0] = 1'b1;
		end
		stall_cycle++;
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= stall_pat[stall_cycle % 8];
			2: rsp.ready <= ($urandom_range(0, 3) == 0);
			default: rsp.ready <= 1'($urandom_range(0, 1));
		endcase
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	// called at a falling edge; returns at a falling edge after the transfer and after any idle gap that ends a burst
	task automatic push_op(input kind_t k, input logic [ID_W-1:0] id,
			input logic [CLS_W-1:0] cls, input logic [ITEMS_W-1:0] items);
		int gap;
		req.kind <= k;
		req.rec_id <= id;
		req.rec_class <= cls;
		req.rec_items <= items;
		req.valid <= 1'b1;
		do @(posedge clk); while (!(req.valid && req.ready));
		@(negedge clk);
		ops_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic random_op(input int ins_pct);
		kind_t              k;
		logic [31:0]        rnd;
		logic [ID_W-1:0]    id;
		logic [ITEMS_W-1:0] items;
		rnd = $urandom;
		if ($urandom_range(0, 99) < ins_pct) begin
			k = KIND_INSERT;
		end else begin
			case ($urandom_range(0, 2))
				0: k = KIND_REMOVE;
				1: k = KIND_POP_HEAD;
				default: k = KIND_POP_TAIL;
			endcase
		end
		// a small id pool so that removals mostly hit, and duplicate ids occur
		id = ($urandom_range(0, 3) == 0) ? rnd[15:0] : ID_W'($urandom_range(0, 47));
		// narrow item counts give equal keys when sorting by items
		items = ($urandom_range(0, 2) == 0) ? ITEMS_W'($urandom_range(0, 7)) : rnd[23:16];
		push_op(k, id, rnd[27:24], items);
	endtask

	// drop valid, wait until every result is back or the wait limit is reached, then idle
	task automatic settle(input int limit);
		int waited;
		waited = 0;
		if (req.valid)
			req.valid <= 1'b0;
		while (pending != 0 && waited < limit) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_key(input logic by_items);
		cfg_we <= 1'b1;
		cfg_wdata <= by_items;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_INSERT;
		req.rec_id = '0;
		req.rec_class = '0;
		req.rec_items = '0;
		rsp.ready = 1'b0;
		stall_cycle = 0;
		ops_sent = 0;
		burst_left = 4;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// class key: empty queue, single entry pops, head and equal-key placement
		write_key(1'b0);
		push_op(KIND_POP_HEAD, 16'd0, 4'd0, 8'd0);
		push_op(KIND_POP_TAIL, 16'd0, 4'd0, 8'd0);
		push_op(KIND_REMOVE, 16'd5, 4'd0, 8'd0);
		push_op(KIND_INSERT, 16'h0000, 4'd0, 8'd0);
		push_op(KIND_POP_HEAD, 16'hffff, 4'd15, 8'd255);
		push_op(KIND_INSERT, 16'hffff, 4'd15, 8'd255);
		push_op(KIND_POP_TAIL, 16'd0, 4'd0, 8'd0);
		push_op(KIND_INSERT, 16'd10, 4'd8, 8'd100);
		push_op(KIND_INSERT, 16'd11, 4'd8, 8'd1);
		push_op(KIND_INSERT, 16'd12, 4'd3, 8'd2);
		push_op(KIND_INSERT, 16'd13, 4'd8, 8'd50);
		push_op(KIND_INSERT, 16'd14, 4'd15, 8'd255);
		push_op(KIND_INSERT, 16'd15, 4'd0, 8'd7);
		push_op(KIND_REMOVE, 16'd999, 4'd0, 8'd0);
		push_op(KIND_REMOVE, 16'd11, 4'd0, 8'd0);
		push_op(KIND_INSERT, 16'd12, 4'd9, 8'd9);
		push_op(KIND_REMOVE, 16'd12, 4'd0, 8'd0);
		push_op(KIND_POP_HEAD, 16'd0, 4'd0, 8'd0);
		push_op(KIND_POP_TAIL, 16'd0, 4'd0, 8'd0);
		settle(5000);

		// item count key on a queue that was ordered by class
		write_key(1'b1);
		push_op(KIND_INSERT, 16'd20, 4'd0, 8'd200);
		push_op(KIND_INSERT, 16'd21, 4'd15, 8'd0);
		push_op(KIND_INSERT, 16'd22, 4'd1, 8'd200);
		push_op(KIND_INSERT, 16'hffff, 4'd15, 8'd255);
		push_op(KIND_POP_HEAD, 16'd0, 4'd0, 8'd0);

		for (int p = 0; p < PHASES; p++) begin
			settle(5000);
			write_key(key_plan[p]);
			repeat (PHASE_OPS) random_op(insert_pct[p]);
		end
		settle(5000);

		$display("ran %0d operations over both sort keys, from empty to full queues",
			ops_sent);
		$display("%0d results compared, %0d mismatches", results_checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_ifs.sv
sv/spq_ram.sv
sv/spq_cmp.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue_unit.sv
tb/spq_order_checker.sv
tb/sorted_priority_queue_unit_test.sv
